>>> rtl/core/rwcs_pkg.sv
// ----------------------------------------------------------------------------
// rwcs_pkg
// Shared types and constants for the register write command sequencer:
// item operations, command opcodes, event codes and the result record.
// ----------------------------------------------------------------------------
package rwcs_pkg;

  // Samples taken off a running wait by one tick
  localparam logic [31:0] SAMPLES_PER_TICK = 32'd20;
  // Delay in samples after reset
  localparam logic [31:0] DELAY_RESET      = 32'd500000;

  // Item operations
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  // Command opcodes
  localparam logic [7:0] OPC_WAIT  = 8'd0;
  localparam logic [7:0] OPC_DELAY = 8'd17;
  localparam logic [7:0] OPC_END   = 8'd255;

  // Parse phases; PHASE_DELAY_LAST and PHASE_WRITE_LAST close a command
  localparam logic [2:0] PHASE_IDLE       = 3'd0;
  localparam logic [2:0] PHASE_FIRST      = 3'd1;
  localparam logic [2:0] PHASE_REG_DONE   = 3'd2;
  localparam logic [2:0] PHASE_DELAY_LAST = 3'd4;
  localparam logic [2:0] PHASE_WRITE_LAST = 3'd5;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_WRITE      = 4'd1,
    EV_WAIT       = 4'd2,
    EV_DELAY      = 4'd3,
    EV_ENDMARK    = 4'd4,
    EV_BUSY       = 4'd5,
    EV_TRUNC      = 4'd6,
    EV_STREAM_END = 4'd7,
    EV_HALTED     = 4'd8
  } event_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  bank;
    logic [7:0]  reg_index;
    logic [31:0] value;
    logic        byte_accepted;
  } result_t;

endpackage

>>> rtl/core/rwcs_core.sv
// ----------------------------------------------------------------------------
// rwcs_core
// Command parser state and per-item decode. Computes the result of the item
// held in the input register and updates the sequencer state when it moves on.
// ----------------------------------------------------------------------------
module rwcs_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [1:0]         operation,
  input  logic [7:0]         stream_byte,
  output rwcs_pkg::result_t  result
);

  logic [2:0]  phase,     phase_next;
  logic [7:0]  opcode,    opcode_next;
  logic [7:0]  pend_reg,  pend_reg_next;
  logic [31:0] gather,    gather_next;
  logic [31:0] delay,     delay_next;
  logic [31:0] wait_rem,  wait_rem_next;
  logic        waiting,   waiting_next;
  logic        halted,    halted_next;

  logic [31:0] shifted;
  logic [31:0] tick_rem;

  assign shifted  = {stream_byte, gather[31:8]};
  assign tick_rem = (wait_rem > rwcs_pkg::SAMPLES_PER_TICK) ?
                    wait_rem - rwcs_pkg::SAMPLES_PER_TICK : 32'd0;

  always_comb begin
    phase_next    = phase;
    opcode_next   = opcode;
    pend_reg_next = pend_reg;
    gather_next   = gather;
    delay_next    = delay;
    wait_rem_next = wait_rem;
    waiting_next  = waiting;
    halted_next   = halted;
    result        = '{ev: rwcs_pkg::EV_NONE, bank: 8'd0, reg_index: 8'd0,
                      value: 32'd0, byte_accepted: 1'b0};
    if (halted) begin
      result.ev = rwcs_pkg::EV_HALTED;
    end else begin
      case (operation)
        rwcs_pkg::OP_BYTE: begin
          if (waiting) begin
            result.ev = rwcs_pkg::EV_BUSY;
          end else begin
            result.byte_accepted = 1'b1;
            if (phase == rwcs_pkg::PHASE_IDLE) begin
              if (stream_byte == rwcs_pkg::OPC_WAIT) begin
                wait_rem_next = delay;
                waiting_next  = 1'b1;
                result.ev     = rwcs_pkg::EV_WAIT;
              end else if (stream_byte == rwcs_pkg::OPC_END) begin
                halted_next = 1'b1;
                result.ev   = rwcs_pkg::EV_ENDMARK;
              end else begin
                opcode_next = stream_byte;
                gather_next = 32'd0;
                phase_next  = rwcs_pkg::PHASE_FIRST;
              end
            end else if (opcode == rwcs_pkg::OPC_DELAY) begin
              gather_next = shifted;
              if (phase == rwcs_pkg::PHASE_DELAY_LAST) begin
                delay_next   = shifted;
                phase_next   = rwcs_pkg::PHASE_IDLE;
                result.ev    = rwcs_pkg::EV_DELAY;
                result.value = shifted;
              end else begin
                phase_next = phase + 3'd1;
              end
            end else if (phase == rwcs_pkg::PHASE_FIRST) begin
              pend_reg_next = stream_byte;
              phase_next    = rwcs_pkg::PHASE_REG_DONE;
            end else begin
              gather_next = shifted;
              if (phase >= rwcs_pkg::PHASE_WRITE_LAST) begin
                phase_next       = rwcs_pkg::PHASE_IDLE;
                result.ev        = rwcs_pkg::EV_WRITE;
                result.bank      = opcode;
                result.reg_index = pend_reg;
                result.value     = shifted;
              end else begin
                phase_next = phase + 3'd1;
              end
            end
          end
        end
        rwcs_pkg::OP_TICK: begin
          if (waiting) begin
            wait_rem_next = tick_rem;
            if (tick_rem == 32'd0) begin
              waiting_next = 1'b0;
            end
          end
        end
        rwcs_pkg::OP_END: begin
          result.ev   = (phase != rwcs_pkg::PHASE_IDLE) ? rwcs_pkg::EV_TRUNC :
                                                          rwcs_pkg::EV_STREAM_END;
          halted_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= rwcs_pkg::PHASE_IDLE;
      opcode   <= 8'd0;
      pend_reg <= 8'd0;
      gather   <= 32'd0;
      delay    <= rwcs_pkg::DELAY_RESET;
      wait_rem <= 32'd0;
      waiting  <= 1'b0;
      halted   <= 1'b0;
    end else if (advance) begin
      phase    <= phase_next;
      opcode   <= opcode_next;
      pend_reg <= pend_reg_next;
      gather   <= gather_next;
      delay    <= delay_next;
      wait_rem <= wait_rem_next;
      waiting  <= waiting_next;
      halted   <= halted_next;
    end
  end

  // Halt is final until reset
  assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("rwcs_core: halt cleared without reset");

  // A wait only starts between commands and bytes are refused while it runs
  assert property (@(posedge clk) disable iff (rst)
    waiting |-> phase == rwcs_pkg::PHASE_IDLE)
    else $error("rwcs_core: wait running inside a command");

  // Parse phase never passes the last value byte of a write
  assert property (@(posedge clk) disable iff (rst)
    phase <= rwcs_pkg::PHASE_WRITE_LAST)
    else $error("rwcs_core: parse phase out of range");

  // State moves only with a transfer
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(phase) && $stable(delay) && $stable(waiting))
    else $error("rwcs_core: state changed without a transfer");

endmodule

>>> rtl/core/register_write_command_sequencer.sv
// ----------------------------------------------------------------------------
// register_write_command_sequencer
// Command byte stream sequencer: input register, single-pass decode in
// rwcs_core, result register with valid/stall on both sides.
// Each item passes the input register, then the result register.
// Throughput: one item per cycle while out_stall does not hold the
// result register; both registers advance together.
// Reset (rst, synchronous): pipeline empty, parser idle, delay 500000.
// ----------------------------------------------------------------------------
module register_write_command_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  event_res,
  output logic [7:0]  bank,
  output logic [7:0]  reg_index,
  output logic [31:0] value,
  output logic        byte_accepted
);

  logic              s1_valid;
  logic [1:0]        s1_op;
  logic [7:0]        s1_byte;
  logic              advance;
  rwcs_pkg::result_t res_comb;
  rwcs_pkg::result_t res;

  // Move the held item on when the result register is free or draining
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op   <= operation;
      s1_byte <= stream_byte;
    end
  end

  rwcs_core u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .operation  (s1_op),
    .stream_byte(s1_byte),
    .result     (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

  assign event_res     = res.ev;
  assign bank          = res.bank;
  assign reg_index     = res.reg_index;
  assign value         = res.value;
  assign byte_accepted = res.byte_accepted;

  // A refused byte is never reported as consumed
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (res.ev == rwcs_pkg::EV_BUSY || res.ev == rwcs_pkg::EV_HALTED)
    |-> !res.byte_accepted)
    else $error("sequencer: refused byte marked as consumed");

  // Each transfer into the core yields a result the next cycle
  assert property (@(posedge clk) disable iff (rst) advance |=> out_valid)
    else $error("sequencer: transfer produced no result");

endmodule
